/* rtl/core/wawc_pkg.sv */
// Shared constants, controller states and command/status types for the anagram window counter.
`timescale 1ns / 1ps
`default_nettype none
package wawc_pkg;

	localparam int MAX_PATTERN = 128;
	localparam int ALPHABET    = 26;
	localparam int WILDCARD    = ALPHABET;
	localparam int NSYM        = ALPHABET + 1;

	localparam int SYM_W   = 5;
	localparam int CNT_W   = 8;
	localparam int LEN_W   = 8;
	localparam int MATCH_W = 16;
	localparam int RING_AW = $clog2(MAX_PATTERN);
	localparam int IDX_W   = $clog2(NSYM);
	localparam int DEF_W   = $clog2(ALPHABET * ((1 << CNT_W) - 1) + 1);

	localparam int TDATA_W = 8;
	localparam int TUSER_W = 2;
	localparam int OUT_W   = 16;

	// tuser bit positions
	localparam int TUSER_KIND  = 0;
	localparam int TUSER_FIRST = 1;

	localparam logic KIND_PATTERN = 1'b0;
	localparam logic KIND_TEXT    = 1'b1;

	localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
	localparam logic [MATCH_W-1:0] MATCH_MAX = '1;
	localparam logic [LEN_W:0]     RING_MAX  = (LEN_W + 1)'(MAX_PATTERN);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_PINC,
		S_PRST,
		S_ENTER,
		S_DEC,
		S_INS,
		S_CHK,
		S_WALK,
		S_CMP,
		S_LAST
	} state_t;

	typedef struct packed {
		logic load_item;
		logic clr_pat;
		logic inc_pat;
		logic restart;
		logic count_match;
		logic ring_rd;
		logic dec_old;
		logic fill_inc;
		logic insert;
		logic walk_clr;
		logic walk_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic first;
		logic last;
		logic sym_valid;
		logic plen_full;
		logic len_zero;
		logic fill_ge_len;
		logic fill_eq_len;
		logic walk_last;
		logic match_ok;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

/* rtl/core/wawc_dp.sv */
// Datapath: symbol counters, window ring memory, deficit walk and result register.
`timescale 1ns / 1ps
`default_nettype none
module wawc_dp
	import wawc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [TDATA_W-1:0] s_tdata,
	input  wire logic [TUSER_W-1:0] s_tuser,
	input  wire logic               s_tlast,
	input  wire logic               m_tready,
	output logic                    m_tvalid,
	output logic [OUT_W-1:0]        m_tdata,
	input  wire cmd_t               cmd,
	output sts_t                    sts
);

	logic               kind_q;
	logic               first_q;
	logic               last_q;
	logic [SYM_W-1:0]   sym_q;

	logic [CNT_W-1:0]   pcnt_q [NSYM];
	logic [CNT_W-1:0]   wcnt_q [NSYM];
	logic [LEN_W-1:0]   plen_q;
	logic [LEN_W-1:0]   fill_q;
	logic [RING_AW-1:0] pos_q;
	logic [MATCH_W-1:0] match_q;
	logic [IDX_W-1:0]   walk_idx_q;
	logic [DEF_W-1:0]   def_q;

	logic [SYM_W-1:0]   ring_q [MAX_PATTERN];
	logic [SYM_W-1:0]   ring_rd_q;

	logic               out_vld_q;
	logic [OUT_W-1:0]   out_q;

	logic [LEN_W:0]     rd_sum;
	logic [RING_AW-1:0] rd_idx;
	logic [RING_AW-1:0] pos_nxt;
	logic [CNT_W-1:0]   walk_p;
	logic [CNT_W-1:0]   walk_w;
	logic [CNT_W-1:0]   walk_diff;

	// oldest window entry: (pos - len) mod depth
	always_comb begin
		rd_sum = {1'b0, LEN_W'(pos_q)} + RING_MAX - {1'b0, plen_q};
		if (rd_sum >= RING_MAX)
			rd_sum = rd_sum - RING_MAX;
		rd_idx = rd_sum[RING_AW-1:0];
	end

	assign pos_nxt = (pos_q == RING_AW'(MAX_PATTERN - 1)) ? '0 : pos_q + 1'b1;

	assign walk_p    = pcnt_q[walk_idx_q];
	assign walk_w    = wcnt_q[walk_idx_q];
	assign walk_diff = (walk_p > walk_w) ? walk_p - walk_w : '0;

	// payload capture
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q  <= s_tuser[TUSER_KIND];
			first_q <= s_tuser[TUSER_FIRST];
			last_q  <= s_tlast;
			sym_q   <= s_tdata[SYM_W-1:0];
		end
		if (cmd.load_out)
			out_q <= OUT_W'(match_q);
	end

	// window ring: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.insert)
			ring_q[pos_q] <= sym_q;
		if (cmd.ring_rd)
			ring_rd_q <= ring_q[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q     <= '{default: '0};
			wcnt_q     <= '{default: '0};
			plen_q     <= '0;
			fill_q     <= '0;
			pos_q      <= '0;
			match_q    <= '0;
			walk_idx_q <= '0;
			def_q      <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cmd.clr_pat) begin
				pcnt_q <= '{default: '0};
				plen_q <= '0;
			end
			if (cmd.inc_pat) begin
				if (pcnt_q[sym_q] != CNT_MAX)
					pcnt_q[sym_q] <= pcnt_q[sym_q] + 1'b1;
				plen_q <= plen_q + 1'b1;
			end
			if (cmd.restart) begin
				wcnt_q  <= '{default: '0};
				fill_q  <= '0;
				pos_q   <= '0;
				// empty pattern credits the empty window
				match_q <= (plen_q == '0) ? MATCH_W'(1) : '0;
			end
			if (cmd.count_match && match_q != MATCH_MAX)
				match_q <= match_q + 1'b1;
			if (cmd.dec_old) begin
				if (ring_rd_q < SYM_W'(NSYM) && wcnt_q[ring_rd_q] != '0)
					wcnt_q[ring_rd_q] <= wcnt_q[ring_rd_q] - 1'b1;
				fill_q <= plen_q;
			end
			if (cmd.fill_inc)
				fill_q <= fill_q + 1'b1;
			if (cmd.insert) begin
				if (wcnt_q[sym_q] != CNT_MAX)
					wcnt_q[sym_q] <= wcnt_q[sym_q] + 1'b1;
				pos_q <= pos_nxt;
			end
			if (cmd.walk_clr) begin
				walk_idx_q <= '0;
				def_q      <= '0;
			end
			if (cmd.walk_step) begin
				walk_idx_q <= walk_idx_q + 1'b1;
				def_q      <= def_q + DEF_W'(walk_diff);
			end
			if (cmd.load_out)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	always_comb begin
		sts.kind        = kind_q;
		sts.first       = first_q;
		sts.last        = last_q;
		sts.sym_valid   = sym_q < SYM_W'(NSYM);
		sts.plen_full   = plen_q == LEN_W'(MAX_PATTERN);
		sts.len_zero    = plen_q == '0;
		sts.fill_ge_len = fill_q >= plen_q;
		sts.fill_eq_len = fill_q == plen_q;
		sts.walk_last   = walk_idx_q == IDX_W'(ALPHABET - 1);
		sts.match_ok    = DEF_W'(wcnt_q[WILDCARD]) >= def_q;
		sts.out_free    = !out_vld_q || m_tready;
	end

endmodule
`default_nettype wire

/* rtl/core/wawc_ctrl.sv */
// Controller: sequences pattern loads, window slides and the deficit walk.
`timescale 1ns / 1ps
`default_nettype none
module wawc_ctrl
	import wawc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					state_nxt     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.kind == KIND_PATTERN) begin
					cmd.clr_pat = sts.first;
					state_nxt   = S_PINC;
				end else begin
					cmd.restart = sts.first;
					state_nxt   = S_ENTER;
				end
			end
			S_PINC: begin
				cmd.inc_pat = sts.sym_valid && !sts.plen_full;
				state_nxt   = S_PRST;
			end
			S_PRST: begin
				cmd.restart = 1'b1;
				state_nxt   = S_IDLE;
			end
			S_ENTER: begin
				if (!sts.sym_valid) begin
					state_nxt = S_LAST;
				end else if (sts.len_zero) begin
					cmd.count_match = 1'b1;
					state_nxt       = S_LAST;
				end else if (sts.fill_ge_len) begin
					cmd.ring_rd = 1'b1;
					state_nxt   = S_DEC;
				end else begin
					cmd.fill_inc = 1'b1;
					state_nxt    = S_INS;
				end
			end
			S_DEC: begin
				cmd.dec_old = 1'b1;
				state_nxt   = S_INS;
			end
			S_INS: begin
				cmd.insert = 1'b1;
				state_nxt  = S_CHK;
			end
			S_CHK: begin
				if (sts.fill_eq_len) begin
					cmd.walk_clr = 1'b1;
					state_nxt    = S_WALK;
				end else begin
					state_nxt = S_LAST;
				end
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_last)
					state_nxt = S_CMP;
			end
			S_CMP: begin
				cmd.count_match = sts.match_ok;
				state_nxt       = S_LAST;
			end
			S_LAST: begin
				if (!sts.last) begin
					state_nxt = S_IDLE;
				end else if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

/* rtl/core/wildcard_anagram_window_counter.sv */
// Top level: counts text windows that are wildcard anagrams of a loaded pattern.
//
// Input beats (s_*) carry one symbol: tuser[0] = kind (0 pattern, 1 text),
// tuser[1] = first (starts a new string, clearing its counts), tlast = last
// text symbol. A pattern beat also restarts the text window.
// Each text beat with tlast set yields one output beat: m_tdata = number of
// full windows whose letter deficit is covered by their wildcard count,
// saturating at 65535.
// One beat at a time. After DISPATCH a pattern beat runs PINC and PRST; a text
// beat runs ENTER and LAST for an empty pattern or an invalid symbol, adds INS
// and CHK while the window fills, adds WALK and CMP when it completes the window
// and DEC when it slides a full one: the controller walks the 26 letter counters
// one per cycle through a single read port to sum the deficit, and the slide
// costs a registered ring memory read. A result is registered in S_LAST and
// shows on m_tvalid. The next input beat is accepted while the result waits; a
// new result only stalls the input while the previous one is unconsumed. Reset
// clears all counts, the pattern length and the result; the ring memory needs no
// clearing since only entries written since the text restart are read.
`timescale 1ns / 1ps
`default_nettype none
module wildcard_anagram_window_counter
	import wawc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [TDATA_W-1:0] s_tdata,  // [4:0] symbol, [7:5] zero
	input  wire logic [TUSER_W-1:0] s_tuser,  // [0] kind, [1] first
	input  wire logic               s_tlast,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [OUT_W-1:0]        m_tdata   // [15:0] match_count
);

	cmd_t cmd;
	sts_t sts;

	wawc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wawc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

`ifndef SYNTHESIS
	// one beat in flight: the port closes right after a beat is taken
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while a beat is in flight");

	// a result never overwrites an unconsumed one
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result loaded over a pending beat");

	// text restart and match credit are separate steps
	a_restart_count: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.restart && cmd.count_match))
		else $error("restart and match count in the same cycle");

	// the deficit walk runs only over letter counters after a clear
	a_walk_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_clr |=> cmd.walk_step)
		else $error("walk did not start after clear");
`endif

endmodule
`default_nettype wire
